// ----- rtl/mdss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_pkg: shared types and constants of the descriptor slot counter
// Token format between front and back, type codes, counter widths.
// ----------------------------------------------------------------------------
package mdss_pkg;

   localparam int COUNT_LIMIT = 255;
   localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
   localparam int WIDE_W      = (CNT_W > 9) ? CNT_W : 9;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // type codes
   localparam logic [3:0] CODE_B       = 4'd0;
   localparam logic [3:0] CODE_C       = 4'd1;
   localparam logic [3:0] CODE_D       = 4'd2;
   localparam logic [3:0] CODE_F       = 4'd3;
   localparam logic [3:0] CODE_I       = 4'd4;
   localparam logic [3:0] CODE_J       = 4'd5;
   localparam logic [3:0] CODE_CLASS   = 4'd6;
   localparam logic [3:0] CODE_S       = 4'd7;
   localparam logic [3:0] CODE_Z       = 4'd8;
   localparam logic [3:0] CODE_V       = 4'd9;
   localparam logic [3:0] CODE_UNKNOWN = 4'd10;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_ARRAY  = 8'h5B;
   localparam logic [7:0] CH_CLASS  = 8'h4C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   typedef enum logic [2:0] {
      TOK_SKIP,
      TOK_OPEN,
      TOK_CLOSE,
      TOK_ARRAY,
      TOK_TYPE
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   code;
      logic         first;
      logic         last;
   } token_type;

   typedef struct packed {
      logic [8:0] stack_delta;
      logic       ret_is_array;
      logic [3:0] ret_type;
      logic [1:0] ret_slots;
      logic [7:0] arg_slots;
      logic [7:0] arg_count;
   } result_type;

   function automatic logic [3:0] lookup_code(input logic [7:0] c);
      logic [3:0] code;
      begin
         unique case (c)
            8'h42:   code = CODE_B;
            8'h43:   code = CODE_C;
            8'h44:   code = CODE_D;
            8'h46:   code = CODE_F;
            8'h49:   code = CODE_I;
            8'h4A:   code = CODE_J;
            8'h4C:   code = CODE_CLASS;
            8'h53:   code = CODE_S;
            8'h5A:   code = CODE_Z;
            8'h56:   code = CODE_V;
            default: code = CODE_UNKNOWN;
         endcase
         return code;
      end
   endfunction

   function automatic logic [1:0] category(input logic [3:0] code);
      logic [1:0] slots;
      begin
         case (code)
            CODE_V, CODE_UNKNOWN: slots = 2'd0;
            CODE_D, CODE_J:       slots = 2'd2;
            default:              slots = 2'd1;
         endcase
         return slots;
      end
   endfunction

endpackage

// ----- rtl/mdss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_front: character classifier
// Tracks the class-name flag and turns each character into a token.
// ----------------------------------------------------------------------------
module mdss_front import mdss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] ch,
   input  logic       first,
   input  logic       last,
   input  logic       take,
   output token_type  tok
);

   logic class_ff;
   logic class_in;
   logic class_cur;

   always_comb begin
      class_cur = first ? 1'b0 : class_ff;
      class_in  = class_cur;
      tok.kind  = TOK_SKIP;
      tok.code  = CODE_UNKNOWN;
      tok.first = first;
      tok.last  = last;
      if (class_cur) begin
         // inside a class name only the terminator matters
         if (ch == CH_SEMI) begin
            class_in = 1'b0;
            tok.kind = TOK_TYPE;
            tok.code = CODE_CLASS;
         end
      end else begin
         unique case (ch)
            CH_SPACE, CH_TAB: tok.kind = TOK_SKIP;
            CH_OPEN:          tok.kind = TOK_OPEN;
            CH_CLOSE:         tok.kind = TOK_CLOSE;
            CH_ARRAY:         tok.kind = TOK_ARRAY;
            CH_CLASS:         class_in = 1'b1;
            default: begin
               tok.kind = TOK_TYPE;
               tok.code = lookup_code(ch);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= 1'b0;
      end else if (take) begin
         class_ff <= class_in;
      end
   end

endmodule

// ----- rtl/mdss_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_queue: token queue
// Small flip-flop fifo between classifier and executor.
// ----------------------------------------------------------------------------
module mdss_queue import mdss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output token_type head
);

   token_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ----- rtl/mdss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_back: token executor
// Keeps argument and return state, counts slots, registers the result.
// ----------------------------------------------------------------------------
module mdss_back import mdss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  token_type  tok,
   output logic       tok_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic             in_args_ff,   in_args_in,   in_args_cur;
   logic             array_ff,     array_in,     array_cur;
   logic [CNT_W-1:0] arg_total_ff, arg_total_in, arg_total_cur;
   logic [CNT_W-1:0] slot_total_ff, slot_total_in, slot_total_cur;
   logic [3:0]       ret_code_ff,  ret_code_in,  ret_code_cur;
   logic [1:0]       ret_size_ff,  ret_size_in,  ret_size_cur;
   logic             ret_array_ff, ret_array_in, ret_array_cur;
   logic             valid_ff, valid_in;
   result_type       out_ff, out_in;
   logic [1:0]       slots;
   logic [CNT_W:0]   slot_sum;
   logic [WIDE_W-1:0] delta_wide;
   logic [WIDE_W-1:0] arg_wide;
   logic [WIDE_W-1:0] slot_wide;

   // a non-final token never needs the output register
   assign tok_pop   = tok_valid && (!tok.last || !valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      in_args_cur    = tok.first ? 1'b0         : in_args_ff;
      array_cur      = tok.first ? 1'b0         : array_ff;
      arg_total_cur  = tok.first ? '0           : arg_total_ff;
      slot_total_cur = tok.first ? '0           : slot_total_ff;
      ret_code_cur   = tok.first ? CODE_UNKNOWN : ret_code_ff;
      ret_size_cur   = tok.first ? 2'd0         : ret_size_ff;
      ret_array_cur  = tok.first ? 1'b0         : ret_array_ff;

      in_args_in    = in_args_cur;
      array_in      = array_cur;
      arg_total_in  = arg_total_cur;
      slot_total_in = slot_total_cur;
      ret_code_in   = ret_code_cur;
      ret_size_in   = ret_size_cur;
      ret_array_in  = ret_array_cur;

      slots    = array_cur ? 2'd1 : category(tok.code);
      slot_sum = {1'b0, slot_total_cur} + (CNT_W + 1)'(slots);

      unique case (tok.kind)
         TOK_SKIP:  ;
         TOK_OPEN:  in_args_in = 1'b1;
         TOK_CLOSE: in_args_in = 1'b0;
         TOK_ARRAY: array_in   = 1'b1;
         TOK_TYPE: begin
            array_in = 1'b0;
            if (in_args_cur) begin
               if (arg_total_cur < CNT_W'(COUNT_LIMIT)) begin
                  arg_total_in = arg_total_cur + 1'b1;
               end
               slot_total_in = (slot_sum > (CNT_W + 1)'(COUNT_LIMIT)) ?
                               CNT_W'(COUNT_LIMIT) : slot_sum[CNT_W-1:0];
            end else begin
               ret_code_in  = tok.code;
               ret_size_in  = slots;
               ret_array_in = array_cur;
            end
         end
         default: ;
      endcase

      arg_wide   = WIDE_W'(arg_total_in);
      slot_wide  = WIDE_W'(slot_total_in);
      delta_wide = WIDE_W'(ret_size_in) - slot_wide;

      out_in.arg_count    = arg_wide[7:0];
      out_in.arg_slots    = slot_wide[7:0];
      out_in.ret_slots    = ret_size_in;
      out_in.ret_type     = ret_code_in;
      out_in.ret_is_array = ret_array_in;
      out_in.stack_delta  = delta_wide[8:0];

      valid_in = valid_ff && !out_ready;
      if (tok_pop && tok.last) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_args_ff    <= 1'b0;
         array_ff      <= 1'b0;
         arg_total_ff  <= '0;
         slot_total_ff <= '0;
         ret_code_ff   <= CODE_UNKNOWN;
         ret_size_ff   <= 2'd0;
         ret_array_ff  <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (tok_pop) begin
            in_args_ff    <= in_args_in;
            array_ff      <= array_in;
            arg_total_ff  <= arg_total_in;
            slot_total_ff <= slot_total_in;
            ret_code_ff   <= ret_code_in;
            ret_size_ff   <= ret_size_in;
            ret_array_ff  <= ret_array_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && tok.last) begin
         out_ff <= out_in;
      end
   end

endmodule

// ----- rtl/method_descriptor_stack_size.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// method_descriptor_stack_size: method descriptor slot counter
// Counts arguments and stack slots of a method type descriptor streamed one
// character per transfer, and reports return type and stack delta.
//
//   channel  direction  tdata                   tuser   tlast
//   req_     in         ch                      first   last
//   rsp_     out        result fields (32 bits) -       -
//
// one character per cycle while the token queue is not full; the last character
// of a descriptor passes classifier, token queue, executor and output register
// a two-entry token queue lets the classifier keep taking characters while
// the output register waits on rsp_tready
// synchronous reset clears all flags, counters and the queue
// ----------------------------------------------------------------------------
module method_descriptor_stack_size import mdss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] first
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] arg_count, [15:8] arg_slots,
                                    // [17:16] ret_slots, [21:18] ret_type,
                                    // [22] ret_is_array, [31:23] stack_delta
);

   logic       take;
   logic       full;
   logic       not_empty;
   logic       pop;
   token_type  front_tok;
   token_type  head;
   result_type result;

   assign req_tready = !full;
   assign take       = req_tvalid && !full;
   assign rsp_tdata  = result;

   mdss_front u_front (
      .clock (clock),
      .reset (reset),
      .ch    (req_tdata),
      .first (req_tuser),
      .last  (req_tlast),
      .take  (take),
      .tok   (front_tok)
   );

   mdss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_tok  (front_tok),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   mdss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (not_empty),
      .tok       (head),
      .tok_pop   (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

endmodule

// ----- rtl/mdss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_checker: port checks of the descriptor slot counter
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module mdss_checker import mdss_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // no result and an open input right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("result valid or input closed after reset");

   // return slots only 0, 1 or 2
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3)
      else $error("bad return slot count");

   // void or unknown return without brackets takes no slots
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[22] &&
      (rsp_tdata[21:18] == CODE_V || rsp_tdata[21:18] == CODE_UNKNOWN)
      |-> rsp_tdata[17:16] == 2'd0)
      else $error("void return with nonzero slots");

endmodule

bind method_descriptor_stack_size mdss_checker u_mdss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/tb_method_descriptor_stack_size.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_method_descriptor_stack_size: self-checking bench of the slot counter
// Streams method descriptors one character per transfer: a short table of
// directed rows, then random descriptors, broken ones and byte noise. A
// behavioral predictor computes each result; results are compared field by
// field in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_method_descriptor_stack_size;
   import mdss_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int ITEM_TARGET  = 800;
   localparam int CALM_TAIL_AT = 680;

   typedef struct {
      logic [7:0] ch;
      logic       first;
      logic       last;
      logic       typed;
      result_type want;
   } stim_row_type;

   localparam result_type NO_RETURN = '{stack_delta: 9'd0, ret_is_array: 1'b0,
                                        ret_type: CODE_UNKNOWN, ret_slots: 2'd0,
                                        arg_slots: 8'd0, arg_count: 8'd0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // predictor state
   logic       desc_in_args;
   logic       desc_in_class;
   logic       desc_array;
   logic [7:0] desc_arg_total;
   logic [7:0] desc_slot_total;
   logic [3:0] desc_ret_code;
   logic [1:0] desc_ret_size;
   logic       desc_ret_array;

   result_type pending_results[$];
   logic [7:0] desc_chars[$];
   logic [7:0] prim_letters[9] = '{"B", "C", "D", "F", "I", "J", "S", "Z", "V"};

   int fail_count = 0;
   int items_sent = 0;
   int stall_left = 0;
   bit tx_idle_en = 1'b1;
   bit rx_idle_en = 1'b1;

   stim_row_type directed_rows[26] = '{
      '{CH_OPEN,  1'b1, 1'b0, 1'b0, '0},
      '{"B",      1'b0, 1'b0, 1'b0, '0},
      '{"C",      1'b0, 1'b0, 1'b0, '0},
      '{"F",      1'b0, 1'b0, 1'b0, '0},
      '{"I",      1'b0, 1'b0, 1'b0, '0},
      '{"S",      1'b0, 1'b0, 1'b0, '0},
      '{"Z",      1'b0, 1'b0, 1'b0, '0},
      '{CH_ARRAY, 1'b0, 1'b0, 1'b0, '0},
      '{"V",      1'b0, 1'b0, 1'b0, '0},
      '{CH_CLASS, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF,    1'b0, 1'b0, 1'b0, '0},
      '{CH_SEMI,  1'b0, 1'b0, 1'b0, '0},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
      '{CH_TAB,   1'b0, 1'b0, 1'b0, '0},
      '{"?",      1'b0, 1'b0, 1'b0, '0},
      '{8'h00,    1'b0, 1'b0, 1'b0, '0},
      '{"J",      1'b0, 1'b0, 1'b0, '0},
      '{CH_CLOSE, 1'b0, 1'b0, 1'b0, '0},
      '{CH_ARRAY, 1'b0, 1'b0, 1'b0, '0},
      '{"D",      1'b0, 1'b1, 1'b0, '0},
      // array prefix carried across the parentheses onto a stray semicolon
      '{CH_OPEN,  1'b1, 1'b0, 1'b0, '0},
      '{CH_ARRAY, 1'b0, 1'b0, 1'b0, '0},
      '{CH_CLOSE, 1'b0, 1'b0, 1'b0, '0},
      '{CH_SEMI,  1'b0, 1'b1, 1'b0, '0},
      // class left open at the end, then a lone unknown byte
      '{CH_CLASS, 1'b1, 1'b1, 1'b1, NO_RETURN},
      '{8'hFF,    1'b1, 1'b1, 1'b1, NO_RETURN}
   };

   method_descriptor_stack_size u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [3:0] letter_code(input logic [7:0] c);
      case (c)
         "B":     return CODE_B;
         "C":     return CODE_C;
         "D":     return CODE_D;
         "F":     return CODE_F;
         "I":     return CODE_I;
         "J":     return CODE_J;
         "S":     return CODE_S;
         "Z":     return CODE_Z;
         "V":     return CODE_V;
         default: return CODE_UNKNOWN;
      endcase
   endfunction

   function automatic logic [1:0] slot_width(input logic [3:0] code);
      if (code == CODE_V || code == CODE_UNKNOWN) return 2'd0;
      if (code == CODE_D || code == CODE_J) return 2'd2;
      return 2'd1;
   endfunction

   function automatic void close_type(input logic [3:0] code);
      logic [1:0] slots;
      logic [8:0] sum;
      slots = desc_array ? 2'd1 : slot_width(code);
      if (desc_in_args) begin
         if (desc_arg_total < COUNT_LIMIT) desc_arg_total = desc_arg_total + 8'd1;
         sum = {1'b0, desc_slot_total} + 9'(slots);
         desc_slot_total = (sum > COUNT_LIMIT) ? 8'(COUNT_LIMIT) : sum[7:0];
      end else begin
         desc_ret_code  = code;
         desc_ret_size  = slots;
         desc_ret_array = desc_array;
      end
      desc_array = 1'b0;
   endfunction

   function automatic void clear_descriptor();
      desc_in_args    = 1'b0;
      desc_in_class   = 1'b0;
      desc_array      = 1'b0;
      desc_arg_total  = 8'd0;
      desc_slot_total = 8'd0;
      desc_ret_code   = CODE_UNKNOWN;
      desc_ret_size   = 2'd0;
      desc_ret_array  = 1'b0;
   endfunction

   // returns 1 when the character closes a descriptor and yields a result
   function automatic bit descriptor_step(input logic [7:0] c, input logic first,
                                          input logic last, output result_type res);
      if (first) clear_descriptor();
      if (desc_in_class) begin
         if (c == CH_SEMI) begin
            desc_in_class = 1'b0;
            close_type(CODE_CLASS);
         end
      end else if (c == CH_SPACE || c == CH_TAB) begin
      end else if (c == CH_OPEN) begin
         desc_in_args = 1'b1;
      end else if (c == CH_CLOSE) begin
         desc_in_args = 1'b0;
      end else if (c == CH_ARRAY) begin
         desc_array = 1'b1;
      end else if (c == CH_CLASS) begin
         desc_in_class = 1'b1;
      end else begin
         close_type(letter_code(c));
      end
      res.arg_count    = desc_arg_total;
      res.arg_slots    = desc_slot_total;
      res.ret_slots    = desc_ret_size;
      res.ret_type     = desc_ret_code;
      res.ret_is_array = desc_ret_array;
      res.stack_delta  = {7'd0, desc_ret_size} - {1'b0, desc_slot_total};
      return last;
   endfunction

   // ---------------------------------------------------------------- sender

   task automatic send_char(input logic [7:0] c, input logic first, input logic last,
                            input logic typed, input result_type want);
      result_type res;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (descriptor_step(c, first, last, res)) begin
         if (typed) res = want;
         pending_results = {pending_results, res};
      end
      if (!(c == CH_SPACE || c == CH_TAB) || first || last) items_sent++;
   endtask

   task automatic wait_results_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic append_char(input logic [7:0] c);
      desc_chars = {desc_chars, c};
   endtask

   task automatic push_type();
      int         k;
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) append_char(CH_ARRAY);
      k = $urandom_range(0, 11);
      if (k < 9) begin
         append_char(prim_letters[k]);
      end else if (k < 11) begin
         append_char(CH_CLASS);
         repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SEMI) b = "x";
            append_char(b);
         end
         append_char(CH_SEMI);
      end else begin
         append_char("?");
      end
      if ($urandom_range(0, 7) == 0)
         append_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic build_descriptor(input int n_args);
      desc_chars.delete();
      if ($urandom_range(0, 5) == 0) append_char(CH_SPACE);
      append_char(CH_OPEN);
      repeat (n_args) push_type();
      append_char(CH_CLOSE);
      case ($urandom_range(0, 5))
         0:       ;
         1:       append_char(8'($urandom_range(0, 255)));
         default: push_type();
      endcase
   endtask

   task automatic send_descriptor(input logic with_first);
      foreach (desc_chars[i])
         send_char(desc_chars[i], with_first && i == 0, i == desc_chars.size() - 1,
                   1'b0, '0);
   endtask

   task automatic send_noise();
      logic [7:0] b;
      logic [7:0] specials[7];
      specials = '{CH_OPEN, CH_CLOSE, CH_ARRAY, CH_CLASS, CH_SEMI, CH_SPACE, CH_TAB};
      repeat ($urandom_range(1, 8)) begin
         b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                  : specials[$urandom_range(0, 6)];
         send_char(b, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      int desc_idx;
      int mode;
      int cut;
      clear_descriptor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
      req_tvalid <= 1'b0;
      wait_results_drained();
      desc_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > CALM_TAIL_AT) begin
            tx_idle_en = 1'b0;
            rx_idle_en = 1'b0;
         end else begin
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 14) == 0) begin
            // hold the sender until every result is back
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait_results_drained();
         end
         mode = $urandom_range(0, 9);
         if (desc_idx == 4) begin
            // long argument list drives both counters into saturation
            build_descriptor($urandom_range(256, 290));
            send_descriptor(1'b1);
         end else if (mode == 0) begin
            send_noise();
         end else begin
            build_descriptor($urandom_range(0, 6));
            if (mode == 1 && desc_chars.size() > 1) begin
               cut = $urandom_range(1, desc_chars.size() - 1);
               while (desc_chars.size() > cut) void'(desc_chars.pop_back());
            end
            send_descriptor(mode != 2);
         end
         desc_idx++;
      end
      req_tvalid <= 1'b0;
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin : rsp_stall
      int n;
      if (stall_left != 0)
         n = stall_left - 1;
      else if (rx_idle_en && $urandom_range(0, 4) == 0)
         n = $urandom_range(1, 4);
      else
         n = 0;
      stall_left <= n;
      rsp_tready <= (n == 0);
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("arg_count", want.arg_count, got.arg_count);
            check_field("arg_slots", want.arg_slots, got.arg_slots);
            check_field("ret_slots", want.ret_slots, got.ret_slots);
            check_field("ret_type", want.ret_type, got.ret_type);
            check_field("ret_is_array", want.ret_is_array, got.ret_is_array);
            check_field("stack_delta", int'($signed(want.stack_delta)),
                        int'($signed(got.stack_delta)));
         end
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
